### hdl/ffha_pkg.sv
// Package: shared types and codes for the first-fit heap allocator.
package ffha_pkg;

   localparam int BUFFER_BYTES = 131072;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FIT    = 2'd1,
      STATUS_NOT_ALLOC = 2'd2,
      STATUS_FULL      = 2'd3
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_A_RD,
      ST_A_CHK,
      ST_A_RM_RD,
      ST_A_RM_WR,
      ST_F_RD,
      ST_F_CHK,
      ST_F_POS_RD,
      ST_F_POS_CHK,
      ST_F_PREV_RD,
      ST_F_PREV_CHK,
      ST_F_DEC,
      ST_F_URM_RD,
      ST_F_URM_WR,
      ST_F_APPLY,
      ST_F_RM_RD,
      ST_F_RM_WR,
      ST_F_INS_RD,
      ST_F_INS_WR,
      ST_F_INS_PUT,
      ST_DONE
   } state_type;

endpackage

### hdl/ffha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module ffha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### hdl/first_fit_heap_allocator.sv
// Top level: first-fit free-list heap allocator with coalescing on free.
//
//  channel | ports                                        | handshake
//  request | req_opcode, req_request_size, req_block_address | start & !busy
//  result  | rsp_status, rsp_data_address, rsp_granted_size,  | rsp_valid, one cycle
//          | rsp_merged_start, rsp_merged_size               |
//
// Each request is handled by a sequencer over one free-table RAM and one
// used-table RAM (one read, one write per cycle each). Allocate scans the free
// table and shifts entries down on removal; free searches the used table,
// scans the free table, and shifts entries. Tables hold 64 entries by default.
// Reset is synchronous; the tables need no clearing pass. The result cannot
// be stalled; busy stays high through the result strobe.
module first_fit_heap_allocator #(
   parameter int HEADER_BYTES = 32,
   parameter int FREE_ENTRIES = 64,
   parameter int USED_ENTRIES = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [17:0] req_request_size,
   input  logic [16:0] req_block_address,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [16:0] rsp_data_address,
   output logic [17:0] rsp_granted_size,
   output logic [16:0] rsp_merged_start,
   output logic [17:0] rsp_merged_size
);

   localparam int FAW = $clog2(FREE_ENTRIES);
   localparam int UAW = $clog2(USED_ENTRIES);
   localparam int FCW = $clog2(FREE_ENTRIES + 1);
   localparam int UCW = $clog2(USED_ENTRIES + 1);
   localparam int EW  = 17 + 18;
   localparam int UEW = 18 + 18;
   localparam logic [17:0] HDR = 18'(HEADER_BYTES);
   localparam logic [17:0] INIT_PL = 18'(ffha_pkg::BUFFER_BYTES - HEADER_BYTES);

   ffha_pkg::state_type state_ff, state_in;

   logic [FCW-1:0] fcnt_ff, fcnt_in;
   logic [UCW-1:0] ucnt_ff, ucnt_in;
   logic           init_ff, init_in;   // free entry 0 still holds its reset value
   logic           op_ff;
   logic [17:0]    size_ff;
   logic [16:0]    addr_ff;
   logic [FCW-1:0] fi_ff, fi_in;
   logic [UCW-1:0] ui_ff, ui_in;
   logic [16:0]    cur_s_ff, cur_s_in;
   logic [17:0]    cur_p_ff, cur_p_in;
   logic [16:0]    pl_s_ff, pl_s_in;  // previous free entry
   logic [17:0]    upl_ff, upl_in;
   logic           mprev_ff, mprev_in, mnext_ff, mnext_in;
   logic [1:0]     st_ff, st_in;
   logic [16:0]    o_a_ff, o_a_in, o_m_ff, o_m_in;
   logic [17:0]    o_g_ff, o_g_in, o_z_ff, o_z_in;
   logic [FCW-1:0] pos_ff;            // insertion slot, latched when the position scan ends

   logic           f_we, u_we;
   logic [FAW-1:0] f_wa, f_ra;
   logic [UAW-1:0] u_wa, u_ra;
   logic [EW-1:0]  f_wd, f_rd_raw;
   logic [UEW-1:0] u_wd, u_rd;
   logic [FCW-1:0] f_ra_w;
   logic [UCW-1:0] u_ra_w;
   logic [16:0]    f_rs;
   logic [17:0]    u_rs;
   logic [17:0]    f_rp, u_rp;
   logic           rd_init_ff;

   ffha_ram #(.WIDTH(EW), .DEPTH(FREE_ENTRIES)) u_free (
      .clock, .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd),
      .rd_addr(f_ra), .rd_data(f_rd_raw));
   ffha_ram #(.WIDTH(UEW), .DEPTH(USED_ENTRIES)) u_used (
      .clock, .wr_en(u_we), .wr_addr(u_wa), .wr_data(u_wd),
      .rd_addr(u_ra), .rd_data(u_rd));

   assign f_ra = f_ra_w[FAW-1:0];
   assign u_ra = u_ra_w[UAW-1:0];

   always_ff @(posedge clock) begin
      rd_init_ff <= init_ff && (f_ra_w == '0);
   end

   assign f_rs = rd_init_ff ? 17'd0 : f_rd_raw[EW-1:18];
   assign f_rp = rd_init_ff ? INIT_PL : f_rd_raw[17:0];
   assign u_rs = u_rd[UEW-1:18];
   assign u_rp = u_rd[17:0];

   logic [18:0] need;
   logic [18:0] cur_end, hdr_end;
   logic [16:0] hdr;
   assign need     = {1'b0, size_ff} + {1'b0, HDR};
   assign hdr      = addr_ff - HDR[16:0];
   assign cur_end  = {2'b0, cur_s_ff} + {1'b0, HDR} + {1'b0, cur_p_ff};
   assign hdr_end  = {2'b0, hdr} + {1'b0, HDR} + {1'b0, upl_ff};

   always_comb begin
      state_in = state_ff;
      fcnt_in = fcnt_ff; ucnt_in = ucnt_ff; init_in = init_ff;
      fi_in = fi_ff; ui_in = ui_ff;
      cur_s_in = cur_s_ff; cur_p_in = cur_p_ff;
      pl_s_in = pl_s_ff; upl_in = upl_ff;
      mprev_in = mprev_ff; mnext_in = mnext_ff; st_in = st_ff;
      o_a_in = o_a_ff; o_g_in = o_g_ff; o_m_in = o_m_ff; o_z_in = o_z_ff;
      f_we = 1'b0; f_wa = fi_ff[FAW-1:0]; f_wd = '0; f_ra_w = fi_ff;
      u_we = 1'b0; u_wa = ucnt_ff[UAW-1:0]; u_wd = '0; u_ra_w = ui_ff;
      unique case (state_ff)
         ffha_pkg::ST_IDLE: begin
            fi_in = '0; ui_in = '0;
            o_a_in = '0; o_g_in = '0; o_m_in = '0; o_z_in = '0;
            st_in = ffha_pkg::STATUS_OK;
            mprev_in = 1'b0; mnext_in = 1'b0;
            if (start) begin
               if (req_opcode == ffha_pkg::OP_ALLOC) begin
                  if (ucnt_ff >= UCW'(USED_ENTRIES)) begin
                     st_in = ffha_pkg::STATUS_FULL; state_in = ffha_pkg::ST_DONE;
                  end else begin
                     state_in = ffha_pkg::ST_A_RD;
                  end
               end else begin
                  state_in = ffha_pkg::ST_F_RD;
               end
            end
         end
         ffha_pkg::ST_A_RD: begin
            f_ra_w = fi_ff;
            if (fi_ff >= fcnt_ff) begin
               st_in = ffha_pkg::STATUS_NO_FIT; state_in = ffha_pkg::ST_DONE;
            end else begin
               state_in = ffha_pkg::ST_A_CHK;
            end
         end
         ffha_pkg::ST_A_CHK: begin
            u_we = 1'b1; u_wa = ucnt_ff[UAW-1:0];
            if ({1'b0, f_rp} >= need) begin
               f_we = 1'b1; f_wa = fi_ff[FAW-1:0];
               f_wd = {17'(f_rs + 17'(need)), 18'(f_rp - 18'(need))};
               if (fi_ff == '0) init_in = 1'b0;
               u_wd = {18'({1'b0, f_rs} + HDR), size_ff};
               ucnt_in = ucnt_ff + 1'b1;
               o_a_in = 17'(f_rs + HDR[16:0]); o_g_in = size_ff;
               state_in = ffha_pkg::ST_DONE;
            end else if (f_rp >= size_ff) begin
               // a zero payload at the buffer end yields a start one past the address range
               u_wd = {18'({1'b0, f_rs} + HDR), f_rp};
               ucnt_in = ucnt_ff + 1'b1;
               o_a_in = 17'(f_rs + HDR[16:0]); o_g_in = f_rp;
               if (fi_ff == '0) init_in = 1'b0;
               fi_in = fi_ff + 1'b1;
               state_in = ffha_pkg::ST_A_RM_RD;
            end else begin
               u_we = 1'b0;
               fi_in = fi_ff + 1'b1;
               state_in = ffha_pkg::ST_A_RD;
            end
         end
         ffha_pkg::ST_A_RM_RD: begin
            f_ra_w = fi_ff;
            if (fi_ff >= fcnt_ff) begin
               fcnt_in = fcnt_ff - 1'b1; state_in = ffha_pkg::ST_DONE;
            end else begin
               state_in = ffha_pkg::ST_A_RM_WR;
            end
         end
         ffha_pkg::ST_A_RM_WR: begin
            f_we = 1'b1; f_wa = FAW'(fi_ff - 1'b1); f_wd = {f_rs, f_rp};
            fi_in = fi_ff + 1'b1;
            state_in = ffha_pkg::ST_A_RM_RD;
         end
         ffha_pkg::ST_F_RD: begin
            u_ra_w = ui_ff;
            if (ui_ff >= ucnt_ff) begin
               st_in = ffha_pkg::STATUS_NOT_ALLOC; state_in = ffha_pkg::ST_DONE;
            end else begin
               state_in = ffha_pkg::ST_F_CHK;
            end
         end
         ffha_pkg::ST_F_CHK: begin
            if (u_rs == {1'b0, addr_ff}) begin
               upl_in = u_rp; fi_in = '0; state_in = ffha_pkg::ST_F_POS_RD;
            end else begin
               ui_in = ui_ff + 1'b1; state_in = ffha_pkg::ST_F_RD;
            end
         end
         ffha_pkg::ST_F_POS_RD: begin
            f_ra_w = fi_ff;
            if (fi_ff >= fcnt_ff) begin
               state_in = ffha_pkg::ST_F_PREV_RD;
            end else begin
               state_in = ffha_pkg::ST_F_POS_CHK;
            end
         end
         ffha_pkg::ST_F_POS_CHK: begin
            if (f_rs > hdr) begin
               cur_s_in = f_rs; cur_p_in = f_rp;
               mnext_in = ({2'b0, f_rs} == hdr_end);
               state_in = ffha_pkg::ST_F_PREV_RD;
            end else begin
               fi_in = fi_ff + 1'b1; state_in = ffha_pkg::ST_F_POS_RD;
            end
         end
         ffha_pkg::ST_F_PREV_RD: begin
            f_ra_w = fi_ff - 1'b1;
            if (fi_ff == '0) begin
               state_in = ffha_pkg::ST_F_DEC;
            end else begin
               state_in = ffha_pkg::ST_F_PREV_CHK;
            end
         end
         ffha_pkg::ST_F_PREV_CHK: begin
            pl_s_in = f_rs;
            mprev_in = ({2'b0, f_rs} + {1'b0, HDR} + {1'b0, f_rp}) == {2'b0, hdr};
            state_in = ffha_pkg::ST_F_DEC;
         end
         ffha_pkg::ST_F_DEC: begin
            if (!mprev_ff && !mnext_ff && fcnt_ff >= FCW'(FREE_ENTRIES)) begin
               st_in = ffha_pkg::STATUS_FULL; state_in = ffha_pkg::ST_DONE;
            end else begin
               ui_in = ui_ff + 1'b1; state_in = ffha_pkg::ST_F_URM_RD;
            end
         end
         ffha_pkg::ST_F_URM_RD: begin
            u_ra_w = ui_ff;
            if (ui_ff >= ucnt_ff) begin
               ucnt_in = ucnt_ff - 1'b1; state_in = ffha_pkg::ST_F_APPLY;
            end else begin
               state_in = ffha_pkg::ST_F_URM_WR;
            end
         end
         ffha_pkg::ST_F_URM_WR: begin
            u_we = 1'b1; u_wa = UAW'(ui_ff - 1'b1); u_wd = {u_rs, u_rp};
            ui_in = ui_ff + 1'b1; state_in = ffha_pkg::ST_F_URM_RD;
         end
         ffha_pkg::ST_F_APPLY: begin
            if (mprev_ff && mnext_ff) begin
               f_we = 1'b1; f_wa = FAW'(fi_ff - 1'b1);
               o_m_in = pl_s_ff;
               o_z_in = 18'(cur_end - {2'b0, pl_s_ff} - {1'b0, HDR});
               f_wd = {pl_s_ff, o_z_in};
               if (fi_ff == FCW'(1)) init_in = 1'b0;
               fi_in = fi_ff + 1'b1;
               state_in = ffha_pkg::ST_F_RM_RD;
            end else if (mprev_ff) begin
               f_we = 1'b1; f_wa = FAW'(fi_ff - 1'b1);
               o_m_in = pl_s_ff;
               o_z_in = 18'(hdr_end - {2'b0, pl_s_ff} - {1'b0, HDR});
               f_wd = {pl_s_ff, o_z_in};
               if (fi_ff == FCW'(1)) init_in = 1'b0;
               state_in = ffha_pkg::ST_DONE;
            end else if (mnext_ff) begin
               f_we = 1'b1; f_wa = fi_ff[FAW-1:0];
               o_m_in = hdr;
               o_z_in = 18'(cur_end - {2'b0, hdr} - {1'b0, HDR});
               f_wd = {hdr, o_z_in};
               if (fi_ff == '0) init_in = 1'b0;
               state_in = ffha_pkg::ST_DONE;
            end else begin
               o_m_in = hdr; o_z_in = upl_ff;
               fi_in = fcnt_ff;
               state_in = ffha_pkg::ST_F_INS_RD;
            end
         end
         ffha_pkg::ST_F_RM_RD: begin
            f_ra_w = fi_ff;
            if (fi_ff >= fcnt_ff) begin
               fcnt_in = fcnt_ff - 1'b1; state_in = ffha_pkg::ST_DONE;
            end else begin
               state_in = ffha_pkg::ST_F_RM_WR;
            end
         end
         ffha_pkg::ST_F_RM_WR: begin
            f_we = 1'b1; f_wa = FAW'(fi_ff - 1'b1); f_wd = {f_rs, f_rp};
            fi_in = fi_ff + 1'b1; state_in = ffha_pkg::ST_F_RM_RD;
         end
         ffha_pkg::ST_F_INS_RD: begin
            // fi_ff is the destination; read the entry just below it
            f_ra_w = fi_ff - 1'b1;
            if (fi_ff == pos_ff) begin
               state_in = ffha_pkg::ST_F_INS_PUT;
            end else begin
               state_in = ffha_pkg::ST_F_INS_WR;
            end
         end
         ffha_pkg::ST_F_INS_WR: begin
            f_we = 1'b1; f_wa = fi_ff[FAW-1:0]; f_wd = {f_rs, f_rp};
            if (fi_ff == FCW'(1)) init_in = 1'b0;
            fi_in = fi_ff - 1'b1; state_in = ffha_pkg::ST_F_INS_RD;
         end
         ffha_pkg::ST_F_INS_PUT: begin
            f_we = 1'b1; f_wa = fi_ff[FAW-1:0]; f_wd = {hdr, upl_ff};
            if (fi_ff == '0) init_in = 1'b0;
            fcnt_in = fcnt_ff + 1'b1;
            state_in = ffha_pkg::ST_DONE;
         end
         ffha_pkg::ST_DONE: begin
            state_in = ffha_pkg::ST_IDLE;
         end
         default: state_in = ffha_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == ffha_pkg::ST_F_PREV_RD) begin
         pos_ff <= fi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::ST_IDLE;
         fcnt_ff  <= FCW'(1);
         ucnt_ff  <= '0;
         init_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         fcnt_ff  <= fcnt_in;
         ucnt_ff  <= ucnt_in;
         init_ff  <= init_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ffha_pkg::ST_IDLE && start) begin
         op_ff <= req_opcode; size_ff <= req_request_size; addr_ff <= req_block_address;
      end
      fi_ff <= fi_in; ui_ff <= ui_in;
      cur_s_ff <= cur_s_in; cur_p_ff <= cur_p_in;
      pl_s_ff <= pl_s_in; upl_ff <= upl_in;
      mprev_ff <= mprev_in; mnext_ff <= mnext_in; st_ff <= st_in;
      o_a_ff <= o_a_in; o_g_ff <= o_g_in; o_m_ff <= o_m_in; o_z_ff <= o_z_in;
   end

   always_comb begin
      busy             = (state_ff != ffha_pkg::ST_IDLE);
      rsp_valid        = (state_ff == ffha_pkg::ST_DONE);
      rsp_status       = st_ff;
      rsp_data_address = (st_ff == ffha_pkg::STATUS_OK && op_ff == ffha_pkg::OP_ALLOC) ? o_a_ff : '0;
      rsp_granted_size = (st_ff == ffha_pkg::STATUS_OK && op_ff == ffha_pkg::OP_ALLOC) ? o_g_ff : '0;
      rsp_merged_start = (st_ff == ffha_pkg::STATUS_OK && op_ff == ffha_pkg::OP_FREE) ? o_m_ff : '0;
      rsp_merged_size  = (st_ff == ffha_pkg::STATUS_OK && op_ff == ffha_pkg::OP_FREE) ? o_z_ff : '0;
   end

endmodule

### hdl/ffha_checker.sv
// Checker: port-level properties of the heap allocator, bound to the top level.
module ffha_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [16:0] rsp_data_address,
   input logic [17:0] rsp_merged_size
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("busy not raised after request");

   a_rsp_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy) else $error("result not single cycle");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside request");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ffha_pkg::STATUS_OK |->
         rsp_data_address == '0 && rsp_merged_size == '0)
      else $error("failed result carries data");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
   .clock, .reset, .start, .busy, .rsp_valid, .rsp_status,
   .rsp_data_address, .rsp_merged_size);
